FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the interval averager
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset
`define TAIA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included
`define TAIA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/taia_pkg.sv
// Package: word types, sequencer codes and divider status of the interval averager
package taia_pkg;

  localparam int SAMPLE_W = 8;
  localparam int AVG_W    = 16;
  localparam int USED_W   = 16;

  typedef struct packed {
    logic                       mode;
    logic                       x_new;
    logic signed [SAMPLE_W-1:0] x_sample;
    logic                       y_new;
    logic signed [SAMPLE_W-1:0] y_sample;
    logic                       z_new;
    logic signed [SAMPLE_W-1:0] z_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [AVG_W-1:0] avg_x;
    logic signed [AVG_W-1:0] avg_y;
    logic signed [AVG_W-1:0] avg_z;
    logic signed [AVG_W-1:0] avg_all;
    logic [USED_W-1:0]       samples_used;
    logic                    empty_interval;
    logic                    count_saturated;
  } out_word_t;

  // mode codes
  localparam logic MODE_OFFER = 1'b0;
  localparam logic MODE_CLOSE = 1'b1;

  // which quotient the shared divider is working on
  typedef enum logic [1:0] {
    AX_X   = 2'd0,
    AX_Y   = 2'd1,
    AX_Z   = 2'd2,
    AX_ALL = 2'd3
  } taia_axis_t;

  typedef struct packed {
    logic busy;
    logic done;
  } taia_div_stat_t;

endpackage

FILE: hw/rtl/three_axis_interval_averager.sv
// Top level: three-axis interval averager, accumulator plus shared serial divider
//
//  port group  dir  handshake            word
//  in_         in   in_valid/in_ready    in_word_t  (offer sample or close interval)
//  out_        out  out_valid/out_ready  out_word_t (averages of the closed interval)
//
//  Offer word: taken while idle; no result word.
//  Close word: four divisions on the one restoring divider, each one bit per
//    cycle, through the LOAD and RUN states in turn; an empty interval skips
//    the divider and goes straight to the FIN state.
//  in_ready is high only while the sequencer is idle.
//  The result waits in the output register; offers are still taken meanwhile,
//    and the next close holds at its last step until that register is free.
//  Synchronous active-low reset clears sums, count, flags and the sequencer.
module three_axis_interval_averager #(
  parameter int COUNT_BITS    = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  taia_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output taia_pkg::out_word_t  out_word
);
  import taia_pkg::*;
  `include "assert_macros.svh"

  localparam int SUM_W = COUNT_BITS + SAMPLE_W;  // per-axis sum, never overflows
  localparam int TOT_W = SUM_W + 2;              // sum of the three sums
  localparam int DEN_W = COUNT_BITS + 2;         // up to three times the count

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_FIN  = 4'b1000
  } taia_state_t;

  taia_state_t state_r, state_nxt;
  taia_axis_t  sel_r, sel_nxt;
  logic        empty_r, empty_nxt;
  logic [AVG_W-1:0] res_r [4];

  logic        out_valid_r;
  out_word_t   out_word_r;

  logic                    in_acc, offer, close, fin_go;
  logic signed [SUM_W-1:0] sum_x, sum_y, sum_z;
  logic [COUNT_BITS-1:0]   count;
  logic                    dropped;
  logic signed [TOT_W-1:0] div_num;
  logic [DEN_W-1:0]        div_den, cnt_ext;
  logic                    div_start;
  taia_div_stat_t          div_stat;
  logic [AVG_W-1:0]        div_quot;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid & in_ready;
  assign offer    = in_acc & (in_word.mode == MODE_OFFER);
  assign close    = in_acc & (in_word.mode == MODE_CLOSE);
  // result leaves the sequencer once the output register is free
  assign fin_go   = (state_r == ST_FIN) & (!out_valid_r | out_ready);

  taia_acc #(
    .COUNT_BITS (COUNT_BITS),
    .SUM_W      (SUM_W)
  ) u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .offer_i   (offer),
    .word_i    (in_word),
    .clear_i   (fin_go),
    .sum_x_o   (sum_x),
    .sum_y_o   (sum_y),
    .sum_z_o   (sum_z),
    .count_o   (count),
    .dropped_o (dropped)
  );

  // operand select for the shared divider
  assign cnt_ext = DEN_W'(count);
  always_comb begin
    div_den = cnt_ext;
    case (sel_r)
      AX_X:    div_num = TOT_W'(sum_x);
      AX_Y:    div_num = TOT_W'(sum_y);
      AX_Z:    div_num = TOT_W'(sum_z);
      AX_ALL: begin
        div_num = TOT_W'(sum_x) + TOT_W'(sum_y) + TOT_W'(sum_z);
        div_den = cnt_ext + (cnt_ext << 1);
      end
      default: div_num = '0;
    endcase
  end

  assign div_start = (state_r == ST_LOAD);

  taia_div #(
    .MAG_W  (TOT_W),
    .FRAC_W (FRACTION_BITS),
    .DEN_W  (DEN_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .stat_o  (div_stat),
    .quot_o  (div_quot)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    empty_nxt = empty_r;
    case (state_r)
      ST_IDLE: begin
        if (close) begin
          sel_nxt = AX_X;
          if (count == '0) begin
            empty_nxt = 1'b1;
            state_nxt = ST_FIN;
          end else begin
            empty_nxt = 1'b0;
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: state_nxt = ST_RUN;
      ST_RUN: begin
        if (div_stat.done) begin
          if (sel_r == AX_ALL) begin
            state_nxt = ST_FIN;
          end else begin
            sel_nxt   = taia_axis_t'(sel_r + 2'd1);
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_FIN: begin
        if (fin_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sel_r   <= AX_X;
      empty_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      empty_r <= empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_RUN) && div_stat.done) begin
      res_r[sel_r] <= div_quot;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_word_r.avg_x           <= empty_r ? '0 : res_r[AX_X];
      out_word_r.avg_y           <= empty_r ? '0 : res_r[AX_Y];
      out_word_r.avg_z           <= empty_r ? '0 : res_r[AX_Z];
      out_word_r.avg_all         <= empty_r ? '0 : res_r[AX_ALL];
      out_word_r.samples_used    <= USED_W'(count);
      out_word_r.empty_interval  <= empty_r;
      out_word_r.count_saturated <= dropped;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `TAIA_ASSERT(a_out_from_fin, $rose(out_valid_r) |-> ($past(state_r) == ST_FIN), "result word without a finished close")
  `TAIA_ASSERT_ALWAYS(a_div_quiet_idle, (rst_n && state_r == ST_IDLE) |-> !div_stat.busy, "divider running while idle")

endmodule

FILE: hw/rtl/taia_acc.sv
// Running per-axis sums, sample count and drop flag
module taia_acc #(
  parameter int COUNT_BITS = 16,
  parameter int SUM_W      = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    offer_i,
  input  taia_pkg::in_word_t      word_i,
  input  logic                    clear_i,
  output logic signed [SUM_W-1:0] sum_x_o,
  output logic signed [SUM_W-1:0] sum_y_o,
  output logic signed [SUM_W-1:0] sum_z_o,
  output logic [COUNT_BITS-1:0]   count_o,
  output logic                    dropped_o
);
  import taia_pkg::*;
  `include "assert_macros.svh"

  logic signed [SUM_W-1:0] sum_x_r, sum_y_r, sum_z_r;
  logic [COUNT_BITS-1:0]   count_r;
  logic                    dropped_r;
  logic                    flags_ok, full;

  assign flags_ok = word_i.x_new & word_i.y_new & word_i.z_new;
  assign full     = (count_r == {COUNT_BITS{1'b1}});

  always_ff @(posedge clk) begin
    if (!rst_n || clear_i) begin
      sum_x_r   <= '0;
      sum_y_r   <= '0;
      sum_z_r   <= '0;
      count_r   <= '0;
      dropped_r <= 1'b0;
    end else if (offer_i && flags_ok) begin
      if (full) begin
        dropped_r <= 1'b1;
      end else begin
        sum_x_r <= sum_x_r + SUM_W'(word_i.x_sample);
        sum_y_r <= sum_y_r + SUM_W'(word_i.y_sample);
        sum_z_r <= sum_z_r + SUM_W'(word_i.z_sample);
        count_r <= count_r + 1'b1;
      end
    end
  end

  assign sum_x_o   = sum_x_r;
  assign sum_y_o   = sum_y_r;
  assign sum_z_o   = sum_z_r;
  assign count_o   = count_r;
  assign dropped_o = dropped_r;

  `TAIA_ASSERT(a_drop_only_when_full, $rose(dropped_r) |-> ($past(count_r) == {COUNT_BITS{1'b1}}), "drop flag set below full count")

endmodule

FILE: hw/rtl/taia_div.sv
// Shared restoring divider: sign(num) * trunc(|num| * 2^F / den), one quotient bit per cycle
module taia_div #(
  parameter int MAG_W  = 26,
  parameter int FRAC_W = 8,
  parameter int DEN_W  = 18
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start_i,
  input  logic signed [MAG_W-1:0]     num_i,
  input  logic [DEN_W-1:0]            den_i,
  output taia_pkg::taia_div_stat_t    stat_o,
  output logic [taia_pkg::AVG_W-1:0]  quot_o
);
  import taia_pkg::*;
  `include "assert_macros.svh"

  localparam int NUM_W = MAG_W + FRAC_W;
  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] dvd_r;
  logic [DEN_W-1:0] rem_r, den_r;
  logic [AVG_W-1:0] q_r;
  logic             neg_r;
  logic [MAG_W-1:0] mag;
  logic [DEN_W:0]   trial, diff;
  logic             fits;

  assign mag   = num_i[MAG_W-1] ? MAG_W'(-num_i) : MAG_W'(num_i);
  assign trial = {rem_r, dvd_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      dvd_r <= NUM_W'(mag) << FRAC_W;
      rem_r <= '0;
      den_r <= den_i;
      q_r   <= '0;
      neg_r <= num_i[MAG_W-1];
    end else if (busy_r) begin
      dvd_r <= {dvd_r[NUM_W-2:0], 1'b0};
      rem_r <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      q_r   <= {q_r[AVG_W-2:0], fits};
    end
  end

  assign quot_o      = neg_r ? AVG_W'(-q_r) : q_r;
  assign stat_o.busy = busy_r;
  assign stat_o.done = done_r;

  `TAIA_ASSERT(a_done_after_busy, done_r |-> $past(busy_r), "quotient done without a run")

endmodule
